// File: src/rlpg_pkg.sv
// Road layer pixel generator: shared types, command codes, register indexes and constants.
// No dependencies; every other file of the block but rlpg_chan_if imports this package.
package rlpg_pkg;

   localparam int RAM_WORDS    = 2048;
   localparam int RAM_IW       = 11;
   localparam int RAM_AW       = RAM_IW + 1;
   localparam int RAM_DEPTH    = 2 * RAM_WORDS;
   localparam int ROM_BYTES_DEFAULT    = 65536;
   localparam int SCREEN_LINES_DEFAULT = 224;
   localparam int SCREEN_WIDTH_DEFAULT = 320;

   localparam logic [11:0] SCROLL_BASE = 12'h5f8;

   localparam logic [2:0] CSR_ROAD_MODE   = 3'd0;
   localparam logic [2:0] CSR_ROAD_COLOR  = 3'd1;
   localparam logic [2:0] CSR_EDGE_COLOR  = 3'd2;
   localparam logic [2:0] CSR_SKY_COLOR   = 3'd3;
   localparam logic [2:0] CSR_SCROLL_ADJ  = 3'd4;
   localparam logic [2:0] CSR_SCREEN_SHFT = 3'd5;

   localparam logic [7:0] PRIO_MAP [2][8] = '{
      '{8'h80, 8'h81, 8'h81, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h81, 8'h81, 8'h81, 8'h8f, 8'h00, 8'h00, 8'h00, 8'h80}
   };

   typedef enum logic [1:0] {
      CMD_WRITE_RAM = 2'd0,
      CMD_SWAP      = 2'd1,
      CMD_WRITE_PAT = 2'd2,
      CMD_RENDER    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] address;
      logic [15:0] wdata;
      logic [7:0]  line;
      logic [8:0]  column;
   } req_type;

   typedef struct packed {
      logic [10:0] pixel_color;
      logic        draw;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  road_mode;
      logic [10:0] road_color_base;
      logic [10:0] edge_color_base;
      logic [10:0] sky_color_base;
      logic [11:0] scroll_adjust;
      logic [11:0] screen_shift;
   } cfg_type;

   typedef struct packed {
      req_type     req;
      logic [15:0] d0;
      logic [15:0] d1;
   } q_item_type;

endpackage

// File: src/rlpg_chan_if.sv
// Valid/ready channel carrying one beat of a payload struct.
// Payload type is given at instantiation, normally from rlpg_pkg.
interface rlpg_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/rlpg_front.sv
// Front part: accepts beats, applies RAM writes to its copy of the road RAM, tracks the
// bank and reads the two line control words. Depends on rlpg_pkg and rlpg_chan_if.
module rlpg_front (
   input  logic                 clock,
   input  logic                 reset,
   rlpg_chan_if.sink            req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output rlpg_pkg::q_item_type push_item
);
   import rlpg_pkg::*;

   logic [15:0] ram_ff [RAM_DEPTH];
   logic        bank_ff, bank_in;
   logic        valid_ff, valid_in;
   req_type     item_ff;
   logic [15:0] d0_ff, d1_ff;
   logic        adv, take;
   logic [RAM_AW-1:0] wr_addr, rd0_addr, rd1_addr;

   assign adv       = !valid_ff || push_ready;
   assign req.ready = adv;
   assign take      = req.valid && adv;
   assign wr_addr   = {bank_ff, req.payload.address[RAM_IW-1:0]};
   assign rd0_addr  = {~bank_ff, 3'b000, req.payload.line};
   assign rd1_addr  = {~bank_ff, 3'b001, req.payload.line};

   always_comb begin
      valid_in = adv ? req.valid : valid_ff;
      bank_in  = bank_ff ^ (take && req.payload.command == CMD_SWAP);
   end

   always_ff @(posedge clock) begin
      if (take && req.payload.command == CMD_WRITE_RAM) begin
         ram_ff[wr_addr] <= req.payload.wdata;
      end
      if (adv) begin
         d0_ff   <= ram_ff[rd0_addr];
         d1_ff   <= ram_ff[rd1_addr];
         item_ff <= req.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         bank_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         bank_ff  <= bank_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = '{req: item_ff, d0: d0_ff, d1: d1_ff};
endmodule

// File: src/rlpg_queue.sv
// Two-entry queue between the front and back parts.
// Depends on rlpg_pkg for the queued item type.
module rlpg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rlpg_pkg::q_item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rlpg_pkg::q_item_type pop_item
);
   import rlpg_pkg::*;

   q_item_type  slot_ff [2];
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end
endmodule

// File: src/rlpg_back.sv
// Back part: three stages (scroll/colour word read, pattern fetch, colour resolve) and an
// output register. Holds its own copies of the road RAM and pattern ROM. Depends on rlpg_pkg.
module rlpg_back #(
   parameter int ROM_BYTES    = rlpg_pkg::ROM_BYTES_DEFAULT,
   parameter int SCREEN_LINES = rlpg_pkg::SCREEN_LINES_DEFAULT,
   parameter int SCREEN_WIDTH = rlpg_pkg::SCREEN_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rlpg_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  rlpg_pkg::q_item_type pop_item,
   rlpg_chan_if.source          rsp
);
   import rlpg_pkg::*;

   localparam int ROM_AW  = $clog2(ROM_BYTES);
   localparam int COL_LIM = SCREEN_WIDTH - (SCREEN_WIDTH % 2);

   function automatic logic [ROM_AW-1:0] rom_wrap(input logic [15:0] v);
      logic [16:0] w;
      w = {1'b0, v};
      if (w >= 17'(ROM_BYTES)) begin
         w = w - 17'(ROM_BYTES);
      end
      return w[ROM_AW-1:0];
   endfunction

   function automatic logic [2:0] pix(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [8:0] x);
      logic [2:0] sel;
      logic [1:0] v;
      sel = 3'd7 - x[2:0];
      v   = {b1[sel], b0[sel]};
      if (x[8:3] == 6'b011111 && v == 2'd3) begin
         return 3'd7;
      end
      return {1'b0, v};
   endfunction

   function automatic logic [10:0] road_color(input logic road, input logic [2:0] p,
                                              input logic [15:0] cw, input logic [15:0] dw,
                                              input cfg_type c);
      logic [3:0] nib;
      nib = road ? cw[7:4] : cw[3:0];
      if (p == 3'd3) begin
         if (dw[9]) begin
            return c.road_color_base ^ {7'd0, road, 2'b00, nib[0]};
         end
         return c.edge_color_base ^ {6'd0, road, nib ^ nib} ^ {7'd0, cw[11:8]};
      end
      if (p == 3'd7) begin
         return c.road_color_base ^ {7'd0, road, 3'b110} ^ {10'd0, nib[3]};
      end
      return c.road_color_base ^ {7'd0, road, p[1:0], 1'b0} ^ {10'd0, nib[p[1:0]]};
   endfunction

   logic [15:0] ram_b_ff [RAM_DEPTH];
   logic [15:0] ram_c_ff [RAM_DEPTH];
   logic [7:0]  pat0_ff [ROM_BYTES];
   logic [7:0]  pat1_ff [ROM_BYTES];

   logic adv, take;
   logic bank_ff, bank_in;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   // stage 1 (queue head)
   logic [1:0] mode;
   logic s0, s1, fg, in_raster;
   logic [8:0] i0, i1;
   logic [RAM_AW-1:0] wr_addr;

   // stage 2
   logic        s2_valid_ff, s2_render_ff, s2_raster_ff, s2_fg_ff;
   req_type     s2_item_ff;
   logic [15:0] s2_d0_ff, s2_d1_ff, s2_hp0_ff, s2_hp1_ff, s2_c0_ff, s2_c1_ff;
   logic [11:0] shift, h0, h1;

   // stage 3
   logic        s3_valid_ff, s3_render_ff, s3_raster_ff, s3_fg_ff;
   logic [15:0] s3_d0_ff, s3_d1_ff, s3_c0_ff, s3_c1_ff;
   logic [11:0] s3_h0_ff, s3_h1_ff;
   logic [7:0]  s3_b00_ff, s3_b01_ff, s3_b10_ff, s3_b11_ff;
   logic [2:0]  p0, p1;
   logic        top1, have;
   logic [15:0] sky_d;
   logic [7:0]  prio;

   assign adv       = !out_valid_ff || rsp.ready;
   assign pop_ready = adv;
   assign take      = pop_valid && adv;

   always_comb begin
      mode      = cfg.road_mode[1:0];
      s0        = pop_item.d0[11];
      s1        = pop_item.d1[11];
      fg        = !(s0 && s1) && !(mode == 2'd0 && s0) && !(mode == 2'd3 && s1);
      in_raster = ({1'b0, pop_item.req.line} < 9'(SCREEN_LINES)) &&
                  ({1'b0, pop_item.req.column} < 10'(COL_LIM));
      i0        = cfg.road_mode[2] ? {1'b0, pop_item.req.line} : pop_item.d0[8:0];
      i1        = cfg.road_mode[2] ? {1'b1, pop_item.req.line} : pop_item.d1[8:0];
      wr_addr   = {bank_ff, pop_item.req.address[RAM_IW-1:0]};
      bank_in   = bank_ff ^ (take && pop_item.req.command == CMD_SWAP);
   end

   always_ff @(posedge clock) begin
      if (take && pop_item.req.command == CMD_WRITE_RAM) begin
         ram_b_ff[wr_addr] <= pop_item.req.wdata;
         ram_c_ff[wr_addr] <= pop_item.req.wdata;
      end
      if (adv) begin
         s2_hp0_ff    <= ram_b_ff[{~bank_ff, 2'b01, i0}];
         s2_hp1_ff    <= ram_b_ff[{~bank_ff, 2'b10, i1}];
         s2_c0_ff     <= ram_c_ff[{~bank_ff, 2'b11, i0}];
         s2_c1_ff     <= ram_c_ff[{~bank_ff, 2'b11, i1}];
         s2_item_ff   <= pop_item.req;
         s2_d0_ff     <= pop_item.d0;
         s2_d1_ff     <= pop_item.d1;
         s2_raster_ff <= in_raster;
         s2_fg_ff     <= fg;
      end
   end

   always_comb begin
      shift = SCROLL_BASE + cfg.screen_shift + cfg.scroll_adjust;
      h0    = s2_hp0_ff[11:0] + {3'd0, s2_item_ff.column} - shift;
      h1    = s2_hp1_ff[11:0] + {3'd0, s2_item_ff.column} - shift;
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff && s2_item_ff.command == CMD_WRITE_PAT) begin
         pat0_ff[rom_wrap(s2_item_ff.address)] <= s2_item_ff.wdata[7:0];
         pat1_ff[rom_wrap(s2_item_ff.address)] <= s2_item_ff.wdata[7:0];
      end
      if (adv) begin
         s3_b00_ff    <= pat0_ff[rom_wrap({2'b00, s2_d0_ff[8:1], h0[8:3]})];
         s3_b01_ff    <= pat0_ff[rom_wrap({2'b01, s2_d0_ff[8:1], h0[8:3]})];
         s3_b10_ff    <= pat1_ff[rom_wrap({2'b10, s2_d1_ff[8:1], h1[8:3]})];
         s3_b11_ff    <= pat1_ff[rom_wrap({2'b11, s2_d1_ff[8:1], h1[8:3]})];
         s3_h0_ff     <= h0;
         s3_h1_ff     <= h1;
         s3_d0_ff     <= s2_d0_ff;
         s3_d1_ff     <= s2_d1_ff;
         s3_c0_ff     <= s2_c0_ff;
         s3_c1_ff     <= s2_c1_ff;
         s3_raster_ff <= s2_raster_ff;
         s3_fg_ff     <= s2_fg_ff;
      end
   end

   always_comb begin
      p0 = 3'd3;
      p1 = 3'd3;
      if (!s3_d0_ff[11] && s3_h0_ff[11:9] == 3'd0) begin
         p0 = pix(s3_b00_ff, s3_b01_ff, s3_h0_ff[8:0]);
      end
      if (!s3_d1_ff[11] && s3_h1_ff[11:9] == 3'd0) begin
         p1 = pix(s3_b10_ff, s3_b11_ff, s3_h1_ff[8:0]);
      end
      prio = PRIO_MAP[cfg.road_mode[1]][p0];
      unique case (cfg.road_mode[1:0])
         2'd0:    top1 = 1'b0;
         2'd3:    top1 = 1'b1;
         default: top1 = prio[p1];
      endcase
      // pick the solid line that supplies the sky fill
      have  = 1'b0;
      sky_d = s3_d0_ff;
      unique case (cfg.road_mode[1:0])
         2'd0: begin
            have = s3_d0_ff[11];
         end
         2'd1: begin
            have  = s3_d0_ff[11] || s3_d1_ff[11];
            sky_d = s3_d0_ff[11] ? s3_d0_ff : s3_d1_ff;
         end
         2'd2: begin
            have  = s3_d0_ff[11] || s3_d1_ff[11];
            sky_d = s3_d1_ff[11] ? s3_d1_ff : s3_d0_ff;
         end
         default: begin
            have  = s3_d1_ff[11];
            sky_d = s3_d1_ff;
         end
      endcase
      out_in = '{pixel_color: 11'd0, draw: 1'b0};
      if (s3_raster_ff) begin
         if (s3_fg_ff) begin
            out_in.pixel_color = top1 ? road_color(1'b1, p1, s3_c1_ff, s3_d1_ff, cfg)
                                      : road_color(1'b0, p0, s3_c0_ff, s3_d0_ff, cfg);
            out_in.draw = 1'b1;
         end else if (have) begin
            out_in.pixel_color = {4'd0, sky_d[6:0]} | cfg.sky_color_base;
            out_in.draw = 1'b1;
         end
      end
      out_valid_in = adv ? (s3_valid_ff && s3_render_ff) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_render_ff <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s3_render_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            s2_valid_ff  <= pop_valid;
            s2_render_ff <= pop_item.req.command == CMD_RENDER;
            s3_valid_ff  <= s2_valid_ff;
            s3_render_ff <= s2_render_ff;
         end
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule

// File: src/road_layer_pixel_generator_unit.sv
// Road layer pixel generator, top level. One beat accepted per cycle while rsp does not stall;
// a render beat's pixel passes through the front RAM read register (loaded by the accepting
// edge), the queue, scroll/colour read, pattern fetch and output registers before it is valid
// on rsp. Rate is one beat a cycle unless rsp stalls, set by the three pipelined memory reads.
// Synchronous active-high reset clears control state, the bank select and the registers to
// their defaults; road RAM and pattern ROM contents are undefined until written.
module road_layer_pixel_generator_unit #(
   parameter int ROM_BYTES    = rlpg_pkg::ROM_BYTES_DEFAULT,
   parameter int SCREEN_LINES = rlpg_pkg::SCREEN_LINES_DEFAULT,
   parameter int SCREEN_WIDTH = rlpg_pkg::SCREEN_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rlpg_chan_if.sink   req,
   rlpg_chan_if.source rsp,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import rlpg_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       f_valid, f_ready, b_valid, b_ready;
   q_item_type f_item, b_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_ROAD_MODE:   cfg_in.road_mode       = csr_wdata[2:0];
            CSR_ROAD_COLOR:  cfg_in.road_color_base = csr_wdata[10:0];
            CSR_EDGE_COLOR:  cfg_in.edge_color_base = csr_wdata[10:0];
            CSR_SKY_COLOR:   cfg_in.sky_color_base  = csr_wdata[10:0];
            CSR_SCROLL_ADJ:  cfg_in.scroll_adjust   = csr_wdata;
            CSR_SCREEN_SHFT: cfg_in.screen_shift    = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{road_mode: 3'd0, road_color_base: 11'h400, edge_color_base: 11'h420,
                     sky_color_base: 11'h780, scroll_adjust: 12'd0, screen_shift: 12'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlpg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item)
   );

   rlpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_item   (b_item)
   );

   rlpg_back #(
      .ROM_BYTES    (ROM_BYTES),
      .SCREEN_LINES (SCREEN_LINES),
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (b_valid),
      .pop_ready (b_ready),
      .pop_item  (b_item),
      .rsp       (rsp)
   );
endmodule

// File: bench/tb_top.sv
// Self-checking bench for road_layer_pixel_generator_unit: fills both road RAM banks and the
// pattern ROM, then runs a directed table and random beats under several register settings.
// Depends on rlpg_pkg and rlpg_chan_if from the RTL source folder.
module tb_top;
   import rlpg_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PHASE_BEATS    = 250;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type want;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [11:0] csr_wdata;

   rlpg_chan_if #(.payload_type(req_type)) req_ch ();
   rlpg_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   road_layer_pixel_generator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Bench copy of the block state
   logic [15:0] road_words [2*RAM_WORDS];
   logic [7:0]  pattern_bytes [65536];
   bit          bank_sel;
   cfg_type     regs;

   rsp_type pixels_due [$];
   int      mismatches;
   int      pixels_seen;
   bit      quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(string what, int want, int got);
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   function automatic int unsigned word_rd(int unsigned idx);
      return road_words[(bank_sel ^ 1) * RAM_WORDS + (idx % RAM_WORDS)];
   endfunction

   function automatic int unsigned pattern_px(int unsigned road, int unsigned ln,
                                              int unsigned x);
      int unsigned base, b0, b1, sh, v;
      base = ((ln & 8'hff) * 'h40 + road * 'h8000) % 65536;
      b0 = pattern_bytes[(base + (x >> 3)) % 65536];
      b1 = pattern_bytes[(base + (x >> 3) + 'h4000) % 65536];
      sh = 7 - (x & 7);
      v = ((b0 >> sh) & 1) | (((b1 >> sh) & 1) << 1);
      // edge stripe
      if (x >= 248 && x < 256 && v == 3) v = 7;
      return v;
   endfunction

   function automatic int unsigned road_colour(int unsigned road, int unsigned p,
                                               int unsigned cw, int unsigned dw);
      if (p == 3) begin
         if (dw & 'h200) return regs.road_color_base ^ (road * 8) ^ ((cw >> (road * 4)) & 1);
         return regs.edge_color_base ^ (road * 'h10) ^ ((cw >> 8) & 'hf);
      end
      if (p == 7)
         return regs.road_color_base ^ (road * 8 + 6) ^ ((cw >> (road * 4 + 3)) & 1);
      return regs.road_color_base ^ (road * 8 + 2 * p) ^ ((cw >> (road * 4 + p)) & 1);
   endfunction

   function automatic rsp_type predict_pixel(int unsigned ln, int unsigned col);
      rsp_type     r;
      int unsigned mode, d0, d1, i0, i1, hp0, hp1, c0, c1, shift, h0, h1, p0, p1, c, d;
      bit          s0, s1, fg, top1, have;
      r = '0;
      mode = regs.road_mode & 3;
      if (ln < SCREEN_LINES_DEFAULT && col < (SCREEN_WIDTH_DEFAULT & ~1)) begin
         d0 = word_rd(ln);
         d1 = word_rd('h100 + ln);
         s0 = (d0 & 'h800) != 0;
         s1 = (d1 & 'h800) != 0;
         fg = !(s0 && s1) && !(mode == 0 && s0) && !(mode == 3 && s1);
         if (fg) begin
            i0 = regs.road_mode[2] ? ln : (d0 & 'h1ff);
            i1 = regs.road_mode[2] ? ('h100 + ln) : (d1 & 'h1ff);
            hp0 = word_rd('h200 + i0) & 'hfff;
            hp1 = word_rd('h400 + i1) & 'hfff;
            c0 = word_rd('h600 + i0);
            c1 = word_rd('h600 + i1);
            shift = SCROLL_BASE + regs.screen_shift + regs.scroll_adjust;
            h0 = (hp0 + col - shift) & 'hfff;
            h1 = (hp1 + col - shift) & 'hfff;
            p0 = 3;
            p1 = 3;
            if (!s0 && h0 < 'h200) p0 = pattern_px(0, (d0 >> 1) & 'hff, h0);
            if (!s1 && h1 < 'h200) p1 = pattern_px(1, (d1 >> 1) & 'hff, h1);
            if (mode == 0) top1 = 1'b0;
            else if (mode == 3) top1 = 1'b1;
            else top1 = PRIO_MAP[mode-1][p0 & 7][p1];
            c = top1 ? road_colour(1, p1, c1, d1) : road_colour(0, p0, c0, d0);
            r.pixel_color = c[10:0];
            r.draw = 1'b1;
         end else begin
            have = 1'b1;
            if (mode == 0) begin
               have = s0; d = d0;
            end else if (mode == 1) begin
               have = s0 || s1; d = s0 ? d0 : d1;
            end else if (mode == 2) begin
               have = s0 || s1; d = s1 ? d1 : d0;
            end else begin
               have = s1; d = d1;
            end
            if (have) begin
               c = (d & 'h7f) | regs.sky_color_base;
               r.pixel_color = c[10:0];
               r.draw = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Advance the bench state for one accepted beat; queue the pixel a render gives
   task automatic apply_beat(req_type b, bit fixed, rsp_type want);
      case (b.command)
         CMD_WRITE_RAM: road_words[bank_sel * RAM_WORDS + (b.address % RAM_WORDS)] = b.wdata;
         CMD_SWAP:      bank_sel ^= 1'b1;
         CMD_WRITE_PAT: pattern_bytes[b.address] = b.wdata[7:0];
         default:       pixels_due.push_back(fixed ? want : predict_pixel(b.line, b.column));
      endcase
   endtask

   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(req_type b, bit fixed, rsp_type want, int gap);
      req_ch.valid <= 1'b1;
      req_ch.payload <= b;
      do @(posedge clock); while (!req_ch.ready);
      apply_beat(b, fixed, want);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type make_beat(cmd_type c, int unsigned a, int unsigned w,
                                         int unsigned ln, int unsigned col);
      req_type b;
      b.command = c;
      b.address = a[15:0];
      b.wdata = w[15:0];
      b.line = ln[7:0];
      b.column = col[8:0];
      return b;
   endfunction

   function automatic req_type random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return make_beat(CMD_RENDER, $urandom, $urandom,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 223),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                      : $urandom_range(0, 319));
      if (r < 85) begin
         // bias towards the per-line control words
         if ($urandom_range(0, 1))
            return make_beat(CMD_WRITE_RAM, ($urandom & 'hf800) | $urandom_range(0, 'h1ff),
                             $urandom, $urandom, $urandom);
         return make_beat(CMD_WRITE_RAM, $urandom, $urandom, $urandom, $urandom);
      end
      if (r < 90) return make_beat(CMD_SWAP, $urandom, $urandom, $urandom, $urandom);
      return make_beat(CMD_WRITE_PAT, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Hold the input low and let the pipeline drain before touching the registers
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pixels_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(cfg_type c);
      logic [11:0] vals [6];
      vals = '{12'(c.road_mode), 12'(c.road_color_base), 12'(c.edge_color_base),
               12'(c.sky_color_base), c.scroll_adjust, c.screen_shift};
      for (int i = 0; i < 6; i++) begin
         csr_wen <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      regs = c;
   endtask

   // Response side: check each beat, stall at random, one long hold-off
   initial begin
      int gap_left;
      int hold_left;
      bit held;
      rsp_type exp_px;
      gap_left = 0;
      hold_left = 0;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            pixels_seen++;
            if (pixels_due.size() == 0) begin
               report("unexpected pixel", 0, rsp_ch.payload);
            end else begin
               exp_px = pixels_due.pop_front();
               if (rsp_ch.payload.pixel_color !== exp_px.pixel_color)
                  report("pixel_color", exp_px.pixel_color, rsp_ch.payload.pixel_color);
               if (rsp_ch.payload.draw !== exp_px.draw)
                  report("draw", exp_px.draw, rsp_ch.payload.draw);
            end
         end
         if (!held && pixels_seen >= 100) begin
            held = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) gap_left = gap_len();
         end
      end
   end

   // Watchdog on cycles without any beat or register write
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_wen)
            idle = 0;
         else
            idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      script_row_type script [$];
      cfg_type        c;
      rsp_type        blank;
      blank = '0;
      mismatches = 0;
      pixels_seen = 0;
      quiet = 1'b1;
      bank_sel = 1'b0;
      regs = '{3'd0, 11'h400, 11'h420, 11'h780, 12'd0, 12'd0};
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill both banks and the whole pattern store so no render reads an unwritten entry
      for (int bk = 0; bk < 2; bk++) begin
         for (int a = 0; a < RAM_WORDS; a++)
            send(make_beat(CMD_WRITE_RAM, a, $urandom, 0, 0), 1'b0, blank, 0);
         send(make_beat(CMD_SWAP, 0, 0, 0, 0), 1'b0, blank, 0);
      end
      for (int a = 0; a < 65536; a++)
         send(make_beat(CMD_WRITE_PAT, a, $urandom, 0, 0), 1'b0, blank, 0);

      // Directed table
      script = '{
         '{make_beat(CMD_RENDER, 0, 0, 224, 0), 1'b1, blank},
         '{make_beat(CMD_RENDER, 'hffff, 'hffff, 255, 511), 1'b1, blank},
         '{make_beat(CMD_RENDER, 0, 0, 0, 320), 1'b1, blank},
         '{make_beat(CMD_RENDER, 0, 0, 223, 319), 1'b0, blank},
         '{make_beat(CMD_WRITE_RAM, 'hffff, 'hffff, 255, 511), 1'b0, blank},
         '{make_beat(CMD_WRITE_PAT, 'hffff, 'hffff, 255, 511), 1'b0, blank},
         // both roads solid on line 0
         '{make_beat(CMD_WRITE_RAM, 0, 'h0855, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_RAM, 'h100, 'h082a, 0, 0), 1'b0, blank},
         // line 1: pattern line 0, scroll so column 0 lands on the edge stripe
         '{make_beat(CMD_WRITE_RAM, 1, 'h0000, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_RAM, 'h101, 'h0000, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_RAM, 'h200, 'h06f0, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_RAM, 'h400, 'hf6f0, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_PAT, 31, 'hff, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_PAT, 'h401f, 'hff, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_PAT, 'h801f, 'hff, 0, 0), 1'b0, blank},
         '{make_beat(CMD_WRITE_PAT, 'hc01f, 'hff, 0, 0), 1'b0, blank},
         '{make_beat(CMD_SWAP, 0, 0, 0, 0), 1'b0, blank},
         '{make_beat(CMD_RENDER, 0, 0, 0, 0), 1'b0, blank},
         '{make_beat(CMD_RENDER, 0, 0, 1, 0), 1'b0, blank},
         '{make_beat(CMD_RENDER, 0, 0, 1, 7), 1'b0, blank},
         // scroll past the pattern span
         '{make_beat(CMD_RENDER, 0, 0, 1, 300), 1'b0, blank},
         '{make_beat(CMD_RENDER, 0, 0, 1, 8), 1'b0, blank},
         '{make_beat(CMD_RENDER, 0, 0, 2, 100), 1'b0, blank}
      };
      quiet = 1'b0;
      foreach (script[i]) send(script[i].item, script[i].fixed, script[i].want, gap_len());

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            settle();
            if (ph == 1) c = '{3'd1, 11'd0, 11'd0, 11'd0, 12'd0, 12'd0};
            else if (ph == 2) c = '{3'd2, 11'h7ff, 11'h7ff, 11'h7ff, 12'hfff, 12'hfff};
            else c = '{3'(ph), 11'($urandom), 11'($urandom), 11'($urandom),
                       12'($urandom), 12'($urandom)};
            write_regs(c);
         end
         quiet = (ph == 3);
         for (int n = 0; n < PHASE_BEATS; n++) send(random_beat(), 1'b0, blank, gap_len());
      end

      settle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
